// ----- design/shb_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// No dependencies; imported by shb_sched, shb_round and the top level.
`default_nettype none
package shb_pkg;

	typedef logic [31:0] word_t;

	localparam int BlockBytes = 64;
	localparam int Rounds     = 64;
	localparam int DigestWords = 8;

	localparam logic [7:0] PadMarker = 8'h80;

	localparam word_t ROUND_K [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [DigestWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// schedule window control: byte writes while gathering/padding, shift per round
	typedef struct packed {
		logic       wr_en;
		logic [5:0] wr_pos;
		logic [7:0] wr_byte;
		logic       shift;
	} sched_ctrl_t;

	// compression control
	typedef struct packed {
		logic       init;    // load working vars from chain value
		logic       step;    // run one round
		logic [5:0] rnd;     // round number
		logic       fold;    // chain += working vars
		logic       reload;  // chain back to initial hash
	} round_ctrl_t;

	function automatic word_t ror(input word_t x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic word_t small_sig0(input word_t x);
		small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

// ----- design/shb_sched.sv -----
// Block buffer and message schedule: 16-word window, byte-addressed while filling,
// shifted once per round to produce W[t] at word 0. Depends on shb_pkg.
`default_nettype none
module shb_sched (
	input  wire                  clk,
	input  shb_pkg::sched_ctrl_t ctrl,
	output shb_pkg::word_t       w_cur
);
	import shb_pkg::*;

	word_t w_q [16];
	word_t w_next;

	assign w_next = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
	assign w_cur  = w_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_next;
		end else if (ctrl.wr_en) begin
			// big-endian: byte 0 of a word goes to bits 31:24
			w_q[ctrl.wr_pos[5:2]][{~ctrl.wr_pos[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
		end
	end

endmodule
`default_nettype wire

// ----- design/shb_round.sv -----
// Shared SHA-256 round unit: working variables, one round per cycle while step
// is set, and the chain value with its final fold. Depends on shb_pkg.
`default_nettype none
module shb_round (
	input  wire                              clk,
	input  wire                              arst_n,
	input  shb_pkg::round_ctrl_t             ctrl,
	input  shb_pkg::word_t                   w_cur,
	output logic [shb_pkg::DigestWords-1:0][31:0] chain
);
	import shb_pkg::*;

	word_t v_q     [DigestWords];
	word_t chain_q [DigestWords];
	word_t sum1, sum2;

	assign sum1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[ctrl.rnd] + w_cur;
	assign sum2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		for (int i = 0; i < DigestWords; i++) begin
			chain[i] = chain_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			for (int i = 0; i < DigestWords; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (ctrl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + sum1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= sum1 + sum2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DigestWords; i++) begin
				chain_q[i] <= INIT_HASH[i];
			end
		end else if (ctrl.reload) begin
			for (int i = 0; i < DigestWords; i++) begin
				chain_q[i] <= INIT_HASH[i];
			end
		end else if (ctrl.fold) begin
			for (int i = 0; i < DigestWords; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/sha256_byte_stream_hasher_top.sv -----
// SHA-256 byte stream hasher: sequencer, bit counter, padding and digest output.
// Depends on shb_pkg, shb_sched and shb_round.
//
// Usage:
//   Input stream: one message byte per transaction on s_tdata; s_tuser says the
//   byte is present, s_tlast ends the message (with or without a byte).
//   Output stream: eight transactions per message, digest word 0 first, word
//   index in m_tdata[34:32], m_tlast on word 7.
// Sequence:
//   A byte that does not complete a 64-byte block is written to the buffer.
//   A byte that completes a block starts a compression: 64 rounds in the shared
//   round unit, then a fold of the working variables into the chain value.
//   Message end writes padding one byte per cycle up to the block end, then
//   compresses that block; the padding spans one or two blocks.
//   s_tready is low during the compression after a byte that fills a block,
//   and from an s_tlast transaction until the last digest word has been taken.
// Reset: arst_n clears the sequencer, fill count and bit count and loads the
//   initial hash values. A stalled m_tready holds the current digest word.
`default_nettype none
module sha256_byte_stream_hasher_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire         s_tuser,   // byte_present
	input  wire         s_tlast,   // message_end
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] reserved
	output logic        m_tlast    // last_word
);
	import shb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [5:0]  pos_q;
	logic [5:0]  round_q;
	logic [2:0]  out_idx_q;
	logic [63:0] bits_q;
	logic        end_q;       // message end pending
	logic        final_q;     // running compression holds the length
	logic        padding_q;   // padding already started
	logic        first_q;     // next pad byte is the marker
	logic        need_two_q;  // length does not fit in this block

	logic        acc;
	logic        go_comp;
	logic [5:0]  fill_nx;
	logic [7:0]  pad_byte;
	sched_ctrl_t sched_ctrl;
	round_ctrl_t rnd_ctrl;
	word_t       w_cur;
	logic [DigestWords-1:0][31:0] chain;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid & s_tready;
	assign fill_nx  = fill_q + {5'd0, s_tuser};

	always_comb begin
		if (first_q) begin
			pad_byte = PadMarker;
		end else if (!need_two_q && pos_q[5:3] == 3'b111) begin
			pad_byte = bits_q[{~pos_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign go_comp = (acc & s_tuser & (fill_q == 6'd63))
		| ((state_q == ST_PAD) & (pos_q == 6'd63));

	always_comb begin
		sched_ctrl.wr_en   = (acc & s_tuser) | (state_q == ST_PAD);
		sched_ctrl.wr_pos  = (state_q == ST_PAD) ? pos_q : fill_q;
		sched_ctrl.wr_byte = (state_q == ST_PAD) ? pad_byte : s_tdata;
		sched_ctrl.shift   = (state_q == ST_COMP);
		rnd_ctrl.init      = go_comp;
		rnd_ctrl.step      = (state_q == ST_COMP);
		rnd_ctrl.rnd       = round_q;
		rnd_ctrl.fold      = (state_q == ST_FIN);
		rnd_ctrl.reload    = (state_q == ST_OUT) & m_tready & (out_idx_q == 3'd7);
	end

	shb_sched u_sched (
		.clk   (clk),
		.ctrl  (sched_ctrl),
		.w_cur (w_cur)
	);

	shb_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rnd_ctrl),
		.w_cur  (w_cur),
		.chain  (chain)
	);

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {5'd0, out_idx_q, chain[out_idx_q]};
	assign m_tlast  = (out_idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			pos_q      <= '0;
			round_q    <= '0;
			out_idx_q  <= '0;
			bits_q     <= '0;
			end_q      <= 1'b0;
			final_q    <= 1'b0;
			padding_q  <= 1'b0;
			first_q    <= 1'b0;
			need_two_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (s_tuser) begin
							bits_q <= bits_q + 64'd8;
							fill_q <= fill_nx;
						end
						if (s_tuser && fill_q == 6'd63) begin
							// block full: compress first, pad afterwards if ending
							state_q   <= ST_COMP;
							round_q   <= '0;
							end_q     <= s_tlast;
							final_q   <= 1'b0;
							padding_q <= 1'b0;
						end else if (s_tlast) begin
							state_q    <= ST_PAD;
							pos_q      <= fill_nx;
							first_q    <= 1'b1;
							need_two_q <= (fill_nx[5:3] == 3'b111);
							padding_q  <= 1'b1;
							end_q      <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (pos_q == 6'd63) begin
						state_q <= ST_COMP;
						round_q <= '0;
						final_q <= !need_two_q;
					end else begin
						pos_q <= pos_q + 6'd1;
					end
				end
				ST_COMP: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (final_q) begin
						state_q   <= ST_OUT;
						out_idx_q <= '0;
					end else if (end_q) begin
						state_q    <= ST_PAD;
						pos_q      <= '0;
						first_q    <= !padding_q;
						need_two_q <= 1'b0;
						padding_q  <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							state_q   <= ST_IDLE;
							fill_q    <= '0;
							bits_q    <= '0;
							end_q     <= 1'b0;
							final_q   <= 1'b0;
							padding_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- tb/sha256_digest_check.sv -----
// Checker for the SHA-256 byte stream hasher: watches both stream channels,
// predicts the digest words of every finished message and compares them.
// Depends only on the port layout of sha256_byte_stream_hasher_top.
module sha256_digest_check (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire         s_tuser,   // byte_present
	input  wire         s_tlast,   // message_end
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] reserved
	input  wire         m_tlast,   // last_word
	output int          fail_count,
	output int          pending_words,
	output int          words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam int         LEN_OFFSET = 56;
	localparam int         MAX_SHOWN  = 10;

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	logic [31:0]  chain [8];
	logic [7:0]   blk [64];
	int           fill;
	logic [63:0]  msg_bits;
	digest_word_t expected_words [$];
	int           errs;
	int           n_checked;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void run_compression();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (i = 16; i < 64; i++) begin
			w[i] = w[i-16] + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_CONST[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endfunction

	function automatic void start_message();
		chain    = IV_WORDS;
		fill     = 0;
		msg_bits = '0;
	endfunction

	// one accepted input transaction; a message end queues eight digest words
	function automatic void absorb_item(input logic [7:0] data, input logic present,
			input logic fin);
		int p;
		int j;
		if (present) begin
			blk[fill] = data;
			msg_bits += 64'd8;
			if (fill == 63) begin
				run_compression();
				fill = 0;
			end else
				fill++;
		end
		if (!fin)
			return;
		p = fill;
		blk[p] = PAD_BYTE;
		p++;
		// no room for the length field: pad out and compress an extra block
		if (p > LEN_OFFSET) begin
			while (p < 64) begin
				blk[p] = '0;
				p++;
			end
			run_compression();
			p = 0;
		end
		while (p < LEN_OFFSET) begin
			blk[p] = '0;
			p++;
		end
		for (j = 0; j < 8; j++)
			blk[63-j] = msg_bits[8*j +: 8];
		run_compression();
		for (j = 0; j < 8; j++)
			expected_words.push_back('{chain[j], 3'(j), j == 7});
		start_message();
	endfunction

	function automatic void check_word();
		digest_word_t exp_w;
		if (expected_words.size() == 0) begin
			errs++;
			if (errs <= MAX_SHOWN)
				$display("%0t: digest word with none expected: word %h index %0d last %0b",
					$realtime, m_tdata[31:0], m_tdata[34:32], m_tlast);
			return;
		end
		exp_w = expected_words.pop_front();
		n_checked++;
		if (m_tdata[31:0] !== exp_w.word || m_tdata[34:32] !== exp_w.index ||
				m_tlast !== exp_w.last || m_tdata[39:35] !== 5'b0) begin
			errs++;
			if (errs <= MAX_SHOWN)
				$display("%0t: digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b pad %b",
					$realtime, exp_w.word, exp_w.index, exp_w.last,
					m_tdata[31:0], m_tdata[34:32], m_tlast, m_tdata[39:35]);
		end
	endfunction

	initial begin
		start_message();
		foreach (blk[k])
			blk[k] = '0;
		errs      = 0;
		n_checked = 0;
	end

	// output side first, so a word cannot match an expectation queued at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_word();
			if (s_tvalid && s_tready)
				absorb_item(s_tdata, s_tuser, s_tlast);
			fail_count    <= errs;
			pending_words <= expected_words.size();
			words_checked <= n_checked;
		end
	end

endmodule

// ----- tb/tb_sha256_byte_stream_hasher_top.sv -----
// Testbench top for the SHA-256 byte stream hasher: clock, reset, message
// stimulus with bursty input and a stalling digest receiver, and the verdict.
// Depends on sha256_byte_stream_hasher_top and sha256_digest_check.
module tb_sha256_byte_stream_hasher_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET  = 310;
	localparam int DRAIN_CYCLES = 400;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_pattern_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tuser  = 1'b0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	int fail_count;
	int pending_words;
	int words_checked;

	int burst_left;
	int items_sent;
	int idle_items;
	int msgs_sent;
	int bytes_sent;

	rx_pattern_t rx_mode;
	int          rx_left;

	always #5 clk = ~clk;

	sha256_byte_stream_hasher_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sha256_digest_check digest_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending_words (pending_words),
		.words_checked (words_checked)
	);

	// receiver: stretches of open, random and held-off tready
	initial begin
		rx_mode = RX_OPEN;
		rx_left = 0;
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_pattern_t'($urandom_range(0, 3));
			rx_left = (rx_mode == RX_HOLD) ? $urandom_range(5, 30) : $urandom_range(10, 60);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:   m_tready <= 1'b0;
		endcase
	end

	initial begin
		#(10_000_000);
		$display("tb_sha256_byte_stream_hasher_top failed");
		$finish;
	end

	task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (present || fin)
			items_sent++;
		else
			idle_items++;
		bytes_sent += present;
		msgs_sent  += fin;
	endtask

	// hold the input side until every queued digest word has been taken
	task automatic wait_digests_out();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
	endtask

	// random message; ends on its last byte or on a separate empty end transaction
	task automatic send_message(input int len);
		logic end_on_byte;
		int   i;
		end_on_byte = (len > 0) && $urandom_range(0, 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int len;
		int pick;
		burst_left = 0;
		items_sent = 0;
		idle_items = 0;
		msgs_sent  = 0;
		bytes_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle transactions, empty message, extreme bytes, "abc"
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h5a, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h7f, 1'b1, 1'b1);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'haa, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		wait_digests_out();

		// random messages, a mix of short ones and ones around the block boundary
		while (items_sent + idle_items < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			len  = (pick < 7) ? $urandom_range(0, 15) : $urandom_range(52, 72);
			send_message(len);
			if ($urandom_range(0, 3) == 0)
				wait_digests_out();
		end
		wait_digests_out();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d messages (%0d bytes, %0d idle transactions), %0d digest words",
			msgs_sent, bytes_sent, idle_items, words_checked);
		$display("including empty messages, block-filling bytes and one- and two-block padding");
		if (fail_count == 0 && pending_words == 0)
			$display("tb_sha256_byte_stream_hasher_top passed");
		else
			$display("tb_sha256_byte_stream_hasher_top failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/shb_pkg.sv
design/shb_sched.sv
design/shb_round.sv
design/sha256_byte_stream_hasher_top.sv
tb/sha256_digest_check.sv
tb/tb_sha256_byte_stream_hasher_top.sv
